[design/lsp_pkg.sv]
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared widths, constants and types for the scanner packet parser.
// ----------------------------------------------------------------------------
package lsp_pkg;

  localparam int PACKETS_PER_TURN_DEF    = 60;
  localparam int READINGS_PER_PACKET_DEF = 6;

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 16;
  localparam int ANGLE_W = 9;
  localparam int SUM_W   = 23;

  localparam logic [BYTE_W-1:0]  START_BYTE  = 8'hFA;
  localparam logic [BYTE_W-1:0]  INDEX_BASE  = 8'hA0;
  localparam logic [ANGLE_W-1:0] ANGLE_TOP   = 9'd359;
  localparam logic [WORD_W-1:0]  TIMEOUT_RST = 16'd1000;
  localparam logic [WORD_W-1:0]  WORD_MAX    = 16'hFFFF;

  // input item command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] intensity;
    logic [WORD_W-1:0] range_mm;
    logic [WORD_W-1:0] reserved_word;
  } reading_t;

endpackage

[design/lsp_if.sv]
// ----------------------------------------------------------------------------
// lsp_if
// Valid/ready channels of the scanner packet parser: input items, result
// items and the timeout register write port.
// ----------------------------------------------------------------------------
interface lsp_in_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [lsp_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, cmd, data_byte, input ready);
  modport sink   (input valid, cmd, data_byte, output ready);
endinterface

interface lsp_out_if;
  logic                        valid;
  logic                        ready;
  logic [lsp_pkg::ANGLE_W-1:0] angle_index;
  logic [lsp_pkg::WORD_W-1:0]  intensity;
  logic [lsp_pkg::WORD_W-1:0]  range_mm;
  logic [lsp_pkg::WORD_W-1:0]  reserved_word;
  logic                        last;
  logic                        scan_done;
  logic [lsp_pkg::WORD_W-1:0]  avg_speed;
  logic [lsp_pkg::WORD_W-1:0]  scan_period;

  modport source (output valid, angle_index, intensity, range_mm, reserved_word,
                  last, scan_done, avg_speed, scan_period, input ready);
  modport sink   (input valid, angle_index, intensity, range_mm, reserved_word,
                  last, scan_done, avg_speed, scan_period, output ready);
endinterface

interface lsp_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lsp_pkg::WORD_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[design/lidar_scan_packet_parser.sv]
// ----------------------------------------------------------------------------
// lidar_scan_packet_parser
// Parses the byte stream of a rotating laser range scanner into readings.
// ----------------------------------------------------------------------------
// Takes one item per clock: a received byte or a millisecond tick. A packet is
// two header bytes plus 4 + 6*READINGS_PER_PACKET stored bytes (42 in all by
// default); on its final byte the readings are copied to a drain buffer and
// leave one per cycle on the result channel while it is ready. in_chan.ready
// drops only when a packet's final byte is next while the previous packet's
// readings still wait in the drain buffer. The average motor speed comes from
// a three-stage reciprocal-multiply divider that runs while the packet body
// is still arriving. The timeout register may be written at any time.
// ----------------------------------------------------------------------------
module lidar_scan_packet_parser #(
  parameter int PACKETS_PER_TURN    = lsp_pkg::PACKETS_PER_TURN_DEF,
  parameter int READINGS_PER_PACKET = lsp_pkg::READINGS_PER_PACKET_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lsp_in_if.sink    in_chan,
  lsp_out_if.source out_chan,
  lsp_cfg_if.sink   cfg_chan
);

  localparam int STORE_LEN = 4 + 6 * READINGS_PER_PACKET;
  localparam int BC_W      = $clog2(STORE_LEN);
  localparam int EP_W      = (PACKETS_PER_TURN > 1) ? $clog2(PACKETS_PER_TURN) : 1;
  localparam int RI_W      = (READINGS_PER_PACKET > 1) ? $clog2(READINGS_PER_PACKET) : 1;
  localparam int SUM_W     = lsp_pkg::SUM_W;
  localparam int WORD_W    = lsp_pkg::WORD_W;
  localparam int BYTE_W    = lsp_pkg::BYTE_W;
  localparam int ANGLE_W   = lsp_pkg::ANGLE_W;
  localparam int DIV_K     = SUM_W + 1;
  localparam int REM_W     = $clog2(PACKETS_PER_TURN) + 1;

  localparam logic [BC_W-1:0]    BC_LAST  = BC_W'(STORE_LEN - 1);
  localparam logic [EP_W-1:0]    EP_LAST  = EP_W'(PACKETS_PER_TURN - 1);
  localparam logic [RI_W-1:0]    RI_LAST  = RI_W'(READINGS_PER_PACKET - 1);
  localparam logic [DIV_K:0]     DIV_M    = (DIV_K+1)'((64'd1 << DIV_K) / PACKETS_PER_TURN);
  localparam logic [SUM_W-1:0]   DIV_P    = SUM_W'(PACKETS_PER_TURN);
  localparam logic [ANGLE_W-1:0] RPP_ANG  = ANGLE_W'(READINGS_PER_PACKET);

  // parser state
  logic                hunting_r,   hunting_nxt;
  logic [BYTE_W-1:0]   prev_byte_r, prev_byte_nxt;
  logic                have_first_r, have_first_nxt;
  logic [BC_W-1:0]     byte_count_r, byte_count_nxt;
  logic [EP_W-1:0]     expected_r,  expected_nxt;
  logic [SUM_W-1:0]    speed_sum_r, speed_sum_nxt;
  logic [WORD_W-1:0]   speed_avg_r, speed_avg_nxt;
  logic [WORD_W-1:0]   since_first_r, since_first_nxt;
  logic [WORD_W-1:0]   period_hold_r, period_hold_nxt;
  logic [WORD_W-1:0]   idle_r,      idle_nxt;
  logic [WORD_W-1:0]   timeout_r;

  logic [BYTE_W-1:0]   store_r [STORE_LEN];
  logic [SUM_W-1:0]    pend_sum_r;

  // divider pipeline
  logic [SUM_W-1:0]       div_x1_r;
  logic [SUM_W+DIV_K:0]   div_prod_r;
  logic [SUM_W-1:0]       div_q_r;
  logic [REM_W-1:0]       div_rem_r;
  logic [WORD_W-1:0]      div_avg_r;
  logic [SUM_W-1:0]       div_q_est;

  // drain buffer
  lsp_pkg::reading_t   buf_r [READINGS_PER_PACKET];
  lsp_pkg::reading_t   rd_snap [READINGS_PER_PACKET];
  logic                busy_r;
  logic [RI_W-1:0]     rd_idx_r;
  logic [ANGLE_W-1:0]  angle0_r;
  logic                done_r;
  logic [WORD_W-1:0]   motor_r;
  logic [WORD_W-1:0]   period_r;

  logic                in_acc, out_acc, completing, done_pkt, at_tail;
  logic [WORD_W-1:0]   idle_inc;
  logic [BYTE_W-1:0]   hdr_byte;

  assign at_tail       = !hunting_r && (byte_count_r == BC_LAST);
  assign in_chan.ready = !(busy_r && at_tail);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_acc       = busy_r && out_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign completing = in_acc && (in_chan.cmd == lsp_pkg::CMD_BYTE) && at_tail;
  assign done_pkt   = (expected_r == EP_LAST);
  assign idle_inc   = (idle_r == lsp_pkg::WORD_MAX) ? idle_r : idle_r + 16'd1;
  assign hdr_byte   = lsp_pkg::INDEX_BASE + BYTE_W'(expected_r);

  always_comb begin
    hunting_nxt     = hunting_r;
    prev_byte_nxt   = prev_byte_r;
    have_first_nxt  = have_first_r;
    byte_count_nxt  = byte_count_r;
    expected_nxt    = expected_r;
    speed_sum_nxt   = speed_sum_r;
    speed_avg_nxt   = speed_avg_r;
    since_first_nxt = since_first_r;
    period_hold_nxt = period_hold_r;
    idle_nxt        = idle_r;
    if (in_acc) begin
      if (in_chan.cmd == lsp_pkg::CMD_TICK) begin
        since_first_nxt = (since_first_r == lsp_pkg::WORD_MAX) ? since_first_r
                                                               : since_first_r + 16'd1;
        if (idle_inc >= timeout_r) begin
          // inactivity: back to hunting for packet zero
          hunting_nxt    = 1'b1;
          have_first_nxt = 1'b0;
          prev_byte_nxt  = '0;
          byte_count_nxt = '0;
          expected_nxt   = '0;
          idle_nxt       = '0;
        end else begin
          idle_nxt = idle_inc;
        end
      end else begin
        idle_nxt = '0;
        if (hunting_r) begin
          if (!have_first_r) begin
            prev_byte_nxt  = in_chan.data_byte;
            have_first_nxt = 1'b1;
          end else if (prev_byte_r == lsp_pkg::START_BYTE && in_chan.data_byte == hdr_byte) begin
            hunting_nxt    = 1'b0;
            byte_count_nxt = '0;
            if (expected_r == '0) begin
              speed_sum_nxt   = '0;
              period_hold_nxt = since_first_r;
              since_first_nxt = '0;
            end
          end else begin
            prev_byte_nxt = in_chan.data_byte;
          end
        end else if (byte_count_r == BC_LAST) begin
          speed_sum_nxt  = pend_sum_r;
          if (done_pkt) begin
            speed_avg_nxt = div_avg_r;
          end
          expected_nxt   = done_pkt ? '0 : expected_r + EP_W'(1);
          hunting_nxt    = 1'b1;
          have_first_nxt = 1'b0;
          prev_byte_nxt  = '0;
          byte_count_nxt = '0;
        end else begin
          byte_count_nxt = byte_count_r + BC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunting_r     <= 1'b1;
      prev_byte_r   <= '0;
      have_first_r  <= 1'b0;
      byte_count_r  <= '0;
      expected_r    <= '0;
      speed_sum_r   <= '0;
      speed_avg_r   <= '0;
      since_first_r <= '0;
      period_hold_r <= '0;
      idle_r        <= '0;
      timeout_r     <= lsp_pkg::TIMEOUT_RST;
    end else begin
      hunting_r     <= hunting_nxt;
      prev_byte_r   <= prev_byte_nxt;
      have_first_r  <= have_first_nxt;
      byte_count_r  <= byte_count_nxt;
      expected_r    <= expected_nxt;
      speed_sum_r   <= speed_sum_nxt;
      speed_avg_r   <= speed_avg_nxt;
      since_first_r <= since_first_nxt;
      period_hold_r <= period_hold_nxt;
      idle_r        <= idle_nxt;
      if (cfg_chan.valid) begin
        timeout_r <= cfg_chan.data;
      end
    end
  end

  // packet body store; the running speed sum is formed once the speed word is in
  always_ff @(posedge clk) begin
    if (in_acc && in_chan.cmd == lsp_pkg::CMD_BYTE && !hunting_r) begin
      store_r[byte_count_r] <= in_chan.data_byte;
      if (byte_count_r == BC_W'(1)) begin
        pend_sum_r <= speed_sum_r + SUM_W'({in_chan.data_byte, store_r[0]});
      end
    end
  end

  // pend_sum / PACKETS_PER_TURN: floor reciprocal is at most one short
  assign div_q_est    = div_prod_r[DIV_K +: SUM_W];

  always_ff @(posedge clk) begin
    div_x1_r   <= pend_sum_r;
    div_prod_r <= (SUM_W+DIV_K+1)'(pend_sum_r * DIV_M);
    div_q_r    <= div_q_est;
    div_rem_r  <= REM_W'(div_x1_r - SUM_W'(div_q_est * DIV_P));
    div_avg_r  <= (div_rem_r >= REM_W'(PACKETS_PER_TURN)) ? WORD_W'(div_q_r + SUM_W'(1))
                                                          : WORD_W'(div_q_r);
  end

  always_comb begin
    for (int i = 0; i < READINGS_PER_PACKET; i++) begin
      rd_snap[i].intensity     = {store_r[2 + 6*i + 1], store_r[2 + 6*i]};
      rd_snap[i].range_mm      = {store_r[2 + 6*i + 3], store_r[2 + 6*i + 2]};
      rd_snap[i].reserved_word = {store_r[2 + 6*i + 5], store_r[2 + 6*i + 4]};
    end
  end

  always_ff @(posedge clk) begin
    if (completing) begin
      for (int i = 0; i < READINGS_PER_PACKET; i++) begin
        buf_r[i] <= rd_snap[i];
      end
      angle0_r <= lsp_pkg::ANGLE_TOP - ANGLE_W'(ANGLE_W'(expected_r) * RPP_ANG);
      done_r   <= done_pkt;
      motor_r  <= done_pkt ? div_avg_r : speed_avg_r;
      period_r <= period_hold_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      rd_idx_r <= '0;
    end else if (completing) begin
      busy_r   <= 1'b1;
      rd_idx_r <= '0;
    end else if (out_acc) begin
      if (rd_idx_r == RI_LAST) begin
        busy_r <= 1'b0;
      end else begin
        rd_idx_r <= rd_idx_r + RI_W'(1);
      end
    end
  end

  assign out_chan.valid         = busy_r;
  assign out_chan.angle_index   = angle0_r - ANGLE_W'(rd_idx_r);
  assign out_chan.intensity     = buf_r[rd_idx_r].intensity;
  assign out_chan.range_mm      = buf_r[rd_idx_r].range_mm;
  assign out_chan.reserved_word = buf_r[rd_idx_r].reserved_word;
  assign out_chan.last          = (rd_idx_r == RI_LAST);
  assign out_chan.scan_done     = (rd_idx_r == RI_LAST) && done_r;
  assign out_chan.avg_speed     = motor_r;
  assign out_chan.scan_period   = period_r;

endmodule
